@@ rtl/lpr_pkg.sv @@
// shared types, constants and helpers for the line pixel rasteriser
// no dependencies; imported by every rtl module of the block

package lpr_pkg;

    localparam int COORD_W  = 16;
    localparam int COLOUR_W = 16;
    localparam int DELTA_W  = 17;
    localparam int ERR_W    = 18;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd320;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd240;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [COLOUR_W-1:0] colour_t;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_NEXT  = 1'b1
    } kind_t;

    // clamped item held in the input register
    typedef struct packed {
        kind_t   kind;
        coord_t  x0;
        coord_t  y0;
        coord_t  x1;
        coord_t  y1;
        colour_t colour;
    } lpr_item_t;

    typedef struct packed {
        logic active;
        logic emitted;
    } lpr_status_t;

    // zero limit wraps, so every coordinate becomes the top value
    function automatic coord_t clamp_coord(coord_t v, coord_t limit);
        coord_t top;
        top = limit - 1'b1;
        return (v >= limit) ? top : v;
    endfunction

endpackage

@@ rtl/lpr_in_stage.sv @@
// input register of the rasteriser: unpacks the slave stream and clamps endpoints
// depends on lpr_pkg

module lpr_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  lpr_pkg::coord_t               screen_width,
    input  lpr_pkg::coord_t               screen_height,
    output logic                          item_valid,
    input  logic                          item_ready,
    output lpr_pkg::lpr_item_t            item
);
    import lpr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lpr_item_t item_reg;
    lpr_item_t item_next;
    logic      load;

    assign s_tready = !valid_reg || item_ready;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.kind   = kind_t'(s_tuser);
        item_next.x0     = clamp_coord(s_tdata[15:0],  screen_width);
        item_next.y0     = clamp_coord(s_tdata[31:16], screen_height);
        item_next.x1     = clamp_coord(s_tdata[47:32], screen_width);
        item_next.y1     = clamp_coord(s_tdata[63:48], screen_height);
        item_next.colour = s_tdata[79:64];
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/lpr_step.sv @@
// line state and one walk step per next item, with the result register on the master stream
// depends on lpr_pkg

module lpr_step (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  lpr_pkg::lpr_item_t             item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lpr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output lpr_pkg::lpr_status_t           status
);
    import lpr_pkg::*;

    // line state
    coord_t             cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    coord_t             cur_x_next, cur_y_next, goal_x_next, goal_y_next;
    logic [DELTA_W-1:0] delta_x_reg, delta_y_reg, delta_x_next, delta_y_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               neg_x_reg, neg_y_reg, neg_x_next, neg_y_next;
    colour_t            colour_reg, colour_next;
    logic               active_reg, active_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    coord_t             out_x_reg, out_y_reg;
    colour_t            out_colour_reg;
    logic               out_last_reg;

    logic               advance;
    logic               emit;
    logic               last;

    // start path
    logic               s_neg_x, s_neg_y;
    coord_t             s_dx, s_dy;
    logic [ERR_W-1:0]   half_x, half_y, s_err;

    // step path
    logic signed [ERR_W:0] e_w, dx_w, dy_w, err_sum;
    logic               step_x, step_y;
    coord_t             n_x, n_y;

    assign item_ready = !out_valid_reg || m_tready;
    assign advance    = item_valid && item_ready;

    always_comb begin
        s_neg_x = item.x1 < item.x0;
        s_neg_y = item.y1 < item.y0;
        s_dx    = s_neg_x ? item.x0 - item.x1 : item.x1 - item.x0;
        s_dy    = s_neg_y ? item.y0 - item.y1 : item.y1 - item.y0;
        half_x  = ERR_W'(s_dx[COORD_W-1:1]);
        half_y  = ERR_W'(s_dy[COORD_W-1:1]);
        s_err   = (s_dx > s_dy) ? half_x : -half_y;
    end

    // both tests use the error from the start of the step
    always_comb begin
        e_w     = {err_reg[ERR_W-1], err_reg};
        dx_w    = {2'b00, delta_x_reg};
        dy_w    = {2'b00, delta_y_reg};
        step_x  = (e_w > -dx_w) && (cur_x_reg != goal_x_reg);
        step_y  = (e_w < dy_w)  && (cur_y_reg != goal_y_reg);
        err_sum = e_w - (step_x ? dy_w : '0) + (step_y ? dx_w : '0);
        n_x     = !step_x ? cur_x_reg : (neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1);
        n_y     = !step_y ? cur_y_reg : (neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1);
    end

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        err_next     = err_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        colour_next  = colour_reg;
        emit         = 1'b0;
        if (advance) begin
            case (item.kind)
                KIND_START: begin
                    cur_x_next   = item.x0;
                    cur_y_next   = item.y0;
                    goal_x_next  = item.x1;
                    goal_y_next  = item.y1;
                    delta_x_next = DELTA_W'(s_dx);
                    delta_y_next = DELTA_W'(s_dy);
                    err_next     = s_err;
                    neg_x_next   = s_neg_x;
                    neg_y_next   = s_neg_y;
                    colour_next  = item.colour;
                    emit         = 1'b1;
                end
                KIND_NEXT: begin
                    if (active_reg) begin
                        cur_x_next = n_x;
                        cur_y_next = n_y;
                        err_next   = err_sum[ERR_W-1:0];
                        emit       = 1'b1;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
        last        = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
        active_next = emit ? !last : active_reg;
    end

    always_comb begin
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        goal_x_reg  <= goal_x_next;
        goal_y_reg  <= goal_y_next;
        delta_x_reg <= delta_x_next;
        delta_y_reg <= delta_y_next;
        err_reg     <= err_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        colour_reg  <= colour_next;
        if (emit) begin
            out_x_reg      <= cur_x_next;
            out_y_reg      <= cur_y_next;
            out_colour_reg <= colour_next;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {out_colour_reg, out_y_reg, out_x_reg};
    assign m_tlast        = out_last_reg;
    assign status.active  = active_reg;
    assign status.emitted = emit;

endmodule

@@ rtl/line_pixel_rasterizer.sv @@
// top level of the line pixel rasteriser: config registers, input stage, step stage
// depends on lpr_pkg, lpr_in_stage and lpr_step
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tuser kind; s_tdata start/end points, colour
//  m_        out  m_tvalid/m_tready   m_tdata pixel x, y, colour; m_tlast end point
//  cfg_      in   cfg_wr_en           cfg_index, cfg_wdata (width, height)
//
// one item per cycle sustained while m_tready is high; an item is first held in the
// input register (endpoint clamp), then its pixel is registered in the result register,
// from which the m_ side takes it.
// the step stage's walk of cur/err against the line state sets that rate.
// reset (aresetn low, synchronous) empties both stages, drops any line and
// loads width 320, height 240. a stalled m_ side holds the result register;
// the input register takes one more item before s_tready falls.

module line_pixel_rasterizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: start_x, start_y, end_x, end_y, colour
    input  logic [lpr_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: kind
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: pixel_x, pixel_y, pixel_colour
    output logic [lpr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lpr_pkg::*;

    coord_t      width_reg, width_next;
    coord_t      height_reg, height_next;
    logic        item_valid;
    logic        item_ready;
    lpr_item_t   item;
    lpr_status_t status;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_next  = cfg_wdata;
                REG_SCREEN_HEIGHT: height_next = cfg_wdata;
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    lpr_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    lpr_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .status     (status)
    );

    // a freshly loaded pixel is last exactly when it ended the line
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(status.emitted) |-> (m_tlast == !status.active))
        else $error("last flag and line state disagree");

    // a result only appears when the step stage produced one
    a_out_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(status.emitted))
        else $error("result register loaded without a step");

    // a held item in the input register is not altered
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !item_ready) |=> (item_valid && $stable(item)))
        else $error("input register changed while stalled");

endmodule
